@@ sv/cvr_pkg.sv @@
// Types and fixed sizes for the 5x5 convolution, bias and ReLU stream block.
// No dependencies; imported by conv2d_5x5_relu_stream.
`default_nettype none

package cvr_pkg;

    localparam int IMG_WIDTH   = 28;
    localparam int IMG_HEIGHT  = 28;
    localparam int KERNEL_SIZE = 5;
    localparam int CHANNELS    = 32;
    localparam int DATA_WIDTH  = 16;

    localparam int N_TAPS     = KERNEL_SIZE * KERNEL_SIZE;
    localparam int N_WEIGHTS  = N_TAPS * CHANNELS;
    localparam int LINE_DEPTH = KERNEL_SIZE * IMG_WIDTH;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 10;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 5;
    localparam int CH_W    = 5;
    localparam int ACT_W   = 15;
    localparam int K_W     = $clog2(KERNEL_SIZE);
    localparam int WADDR_W = $clog2(N_WEIGHTS);
    localparam int LADDR_W = $clog2(LINE_DEPTH);
    localparam int PROD_W  = 2 * DATA_WIDTH;
    localparam int ACC_W   = PROD_W + $clog2(N_TAPS + 1) + 2;
    localparam int FRAC_W  = 8;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;

    localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(IMG_HEIGHT - 1);
    localparam logic [COL_W-1:0]   COL_LAST   = COL_W'(IMG_WIDTH - 1);
    localparam logic [ROW_W-1:0]   WIN_ROW    = ROW_W'(KERNEL_SIZE - 1);
    localparam logic [COL_W-1:0]   WIN_COL    = COL_W'(KERNEL_SIZE - 1);
    localparam logic [K_W-1:0]     TAP_LAST   = K_W'(KERNEL_SIZE - 1);
    localparam logic [CH_W-1:0]    CH_LAST    = CH_W'(CHANNELS - 1);
    localparam logic [LADDR_W-1:0] LINE_STEP  = LADDR_W'(IMG_WIDTH);
    localparam logic [LADDR_W-1:0] LINE_LAST  = LADDR_W'((KERNEL_SIZE - 1) * IMG_WIDTH);
    localparam logic [WADDR_W-1:0] WADDR_STEP = WADDR_W'(CHANNELS);
    localparam logic [INDEX_W-1:0] WEIGHT_LIM = INDEX_W'(N_WEIGHTS);
    localparam logic [INDEX_W-1:0] BIAS_LIM   = INDEX_W'(CHANNELS);
    localparam logic [ACT_W-1:0]   ACT_MAX    = {ACT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_PIXEL  = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_BIAS   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MAC   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

endpackage

`default_nettype wire

@@ sv/conv2d_5x5_relu_stream.sv @@
// Valid 5x5 convolution of a 28x28 Q8.8 image with 32 filters, bias and ReLU.
// Depends on cvr_pkg; holds weight, bias and line memories and one shared MAC.
// Loads and pixels without a full window are taken while idle, with tready high. A pixel
// that closes a window holds tready low until all 32 channels are done, each 25 MAC steps
// through the single multiplier plus a read/multiply/accumulate tail, so no new pixel is
// taken until the last channel is out; output stalls add to the wait.
// rst_n clears position, sequencer and output valid at once; memories hold data.
`default_nettype none

module conv2d_5x5_relu_stream
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // index [9:0], value [25:10], zero [31:26]
    input  wire logic [cvr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // operation [1:0], frame_start [2]
    input  wire logic [cvr_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_row [4:0], out_col [9:5], channel [14:10], activation [29:15], zero [31:30]
    output logic [cvr_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output logic                                m_axis_tlast
);

    import cvr_pkg::*;

    logic signed [DATA_WIDTH-1:0] weight_mem [N_WEIGHTS];
    logic signed [DATA_WIDTH-1:0] bias_mem [CHANNELS];
    logic signed [DATA_WIDTH-1:0] line_mem [LINE_DEPTH];

    state_t state_reg, state_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [LADDR_W-1:0] base_reg, base_next;
    logic [CH_W-1:0]    ch_reg, ch_next;
    logic [K_W-1:0]     kx_reg, kx_next;
    logic [K_W-1:0]     ky_reg, ky_next;
    logic [WADDR_W-1:0] waddr_reg, waddr_next;
    logic [LADDR_W-1:0] rbase_reg, rbase_next;
    logic               s1_vld_reg, s1_vld_next;
    logic               s1_first_reg, s1_first_next;
    logic               s1_last_reg, s1_last_next;
    logic               s2_vld_reg, s2_first_reg, s2_last_reg;
    logic               acc_done_reg, acc_done_next;
    logic               m_valid_reg, m_valid_next;

    logic [ROW_W-1:0]   r0_reg;
    logic [COL_W-1:0]   c0_reg;
    logic [LADDR_W-1:0] rstart_reg, rstart_next;
    logic signed [DATA_WIDTH-1:0] line_rd_reg, weight_rd_reg, bias_rd_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic [ROW_W-1:0]   o_row_reg;
    logic [COL_W-1:0]   o_col_reg;
    logic [CH_W-1:0]    o_ch_reg;
    logic [ACT_W-1:0]   o_act_reg, act;
    logic               o_last_reg;

    op_t                in_op;
    logic               in_frame;
    logic [INDEX_W-1:0] in_index;
    logic signed [DATA_WIDTH-1:0] in_value;
    logic               accept, out_free, load_out, window;
    logic               w_we, b_we, l_we;
    logic [ROW_W-1:0]   eff_row;
    logic [COL_W-1:0]   eff_col;
    logic [LADDR_W-1:0] eff_base, line_waddr, line_raddr;
    logic signed [ACC_W-1:0] acc_shift, acc_base, bias_ext, prod_ext;

    assign in_op    = op_t'(s_axis_tuser[OP_W-1:0]);
    assign in_frame = s_axis_tuser[OP_W];
    assign in_index = s_axis_tdata[INDEX_W-1:0];
    assign in_value = s_axis_tdata[INDEX_W +: DATA_WIDTH];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign load_out      = (state_reg == ST_DRAIN) && acc_done_reg && out_free;

    assign eff_row    = in_frame ? '0 : row_reg;
    assign eff_col    = in_frame ? '0 : col_reg;
    assign eff_base   = in_frame ? '0 : base_reg;
    assign line_waddr = eff_base + LADDR_W'(eff_col);
    assign window     = (eff_row >= WIN_ROW) && (eff_col >= WIN_COL);
    assign line_raddr = rbase_reg + LADDR_W'(c0_reg) + LADDR_W'(kx_reg);

    assign w_we = accept && (in_op == OP_WEIGHT) && (in_index < WEIGHT_LIM);
    assign b_we = accept && (in_op == OP_BIAS) && (in_index < BIAS_LIM);
    assign l_we = accept && (in_op == OP_PIXEL);

    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            weight_mem[in_index[WADDR_W-1:0]] <= in_value;
        end
        weight_rd_reg <= weight_mem[waddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            bias_mem[in_index[CH_W-1:0]] <= in_value;
        end
        bias_rd_reg <= bias_mem[ch_reg];
    end

    always_ff @(posedge clk)
    begin
        if (l_we)
        begin
            line_mem[line_waddr] <= in_value;
        end
        line_rd_reg <= line_mem[line_raddr];
    end

    always_comb
    begin
        bias_ext  = {{(ACC_W - DATA_WIDTH){bias_rd_reg[DATA_WIDTH-1]}}, bias_rd_reg};
        prod_ext  = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        acc_base  = s2_first_reg ? (bias_ext <<< FRAC_W) : acc_reg;
        acc_next  = s2_vld_reg ? (acc_base + prod_ext) : acc_reg;
        acc_shift = acc_reg >>> FRAC_W;
        act       = '0;
        if (acc_reg > 0)
        begin
            if (acc_shift > $signed(ACC_W'(ACT_MAX)))
            begin
                act = ACT_MAX;
            end
            else
            begin
                act = acc_shift[ACT_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        base_next     = base_reg;
        ch_next       = ch_reg;
        kx_next       = kx_reg;
        ky_next       = ky_reg;
        waddr_next    = waddr_reg;
        rbase_next    = rbase_reg;
        rstart_next   = rstart_reg;
        s1_vld_next   = 1'b0;
        s1_first_next = 1'b0;
        s1_last_next  = 1'b0;
        acc_done_next = acc_done_reg;
        m_valid_next  = m_valid_reg;

        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (load_out)
        begin
            m_valid_next  = 1'b1;
            acc_done_next = 1'b0;
        end
        else if (s2_vld_reg && s2_last_reg)
        begin
            acc_done_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_op == OP_PIXEL))
                begin
                    if (eff_col == COL_LAST)
                    begin
                        col_next = '0;
                        if (eff_row == ROW_LAST)
                        begin
                            row_next  = '0;
                            base_next = '0;
                        end
                        else
                        begin
                            row_next  = eff_row + 1'b1;
                            base_next = (eff_base == LINE_LAST) ? '0 : eff_base + LINE_STEP;
                        end
                    end
                    else
                    begin
                        col_next  = eff_col + 1'b1;
                        row_next  = eff_row;
                        base_next = eff_base;
                    end
                    if (window)
                    begin
                        rstart_next = (eff_base == LINE_LAST) ? '0 : eff_base + LINE_STEP;
                        rbase_next  = rstart_next;
                        ch_next     = '0;
                        kx_next     = '0;
                        ky_next     = '0;
                        waddr_next  = '0;
                        state_next  = ST_MAC;
                    end
                end
            end
            ST_MAC:
            begin
                s1_vld_next   = 1'b1;
                s1_first_next = (kx_reg == '0) && (ky_reg == '0);
                s1_last_next  = (kx_reg == TAP_LAST) && (ky_reg == TAP_LAST);
                waddr_next    = waddr_reg + WADDR_STEP;
                if (kx_reg == TAP_LAST)
                begin
                    kx_next    = '0;
                    ky_next    = ky_reg + 1'b1;
                    rbase_next = (rbase_reg == LINE_LAST) ? '0 : rbase_reg + LINE_STEP;
                end
                else
                begin
                    kx_next = kx_reg + 1'b1;
                end
                if (s1_last_next)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (load_out)
                begin
                    if (ch_reg == CH_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        kx_next    = '0;
                        ky_next    = '0;
                        waddr_next = WADDR_W'(ch_next);
                        rbase_next = rstart_reg;
                        state_next = ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            ch_reg       <= '0;
            kx_reg       <= '0;
            ky_reg       <= '0;
            waddr_reg    <= '0;
            rbase_reg    <= '0;
            s1_vld_reg   <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            acc_done_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            base_reg     <= base_next;
            ch_reg       <= ch_next;
            kx_reg       <= kx_next;
            ky_reg       <= ky_next;
            waddr_reg    <= waddr_next;
            rbase_reg    <= rbase_next;
            s1_vld_reg   <= s1_vld_next;
            s1_first_reg <= s1_first_next;
            s1_last_reg  <= s1_last_next;
            s2_vld_reg   <= s1_vld_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            acc_done_reg <= acc_done_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rstart_reg <= rstart_next;
        prod_reg   <= line_rd_reg * weight_rd_reg;
        acc_reg    <= acc_next;
        if (accept && (in_op == OP_PIXEL) && window)
        begin
            r0_reg <= eff_row - WIN_ROW;
            c0_reg <= eff_col - WIN_COL;
        end
        if (load_out)
        begin
            o_row_reg  <= r0_reg;
            o_col_reg  <= c0_reg;
            o_ch_reg   <= ch_reg;
            o_act_reg  <= act;
            o_last_reg <= (ch_reg == CH_LAST);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - ROW_W - COL_W - CH_W - ACT_W){1'b0}},
                            o_act_reg, o_ch_reg, o_col_reg, o_row_reg};

endmodule

`default_nettype wire
